// ===== rtl/core/adc_dc_block_gain_saturate_defines.svh =====
// Assertion macros shared by the DC blocking filter RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ADC_DC_BLOCK_GAIN_SATURATE_DEFINES_SVH
`define ADC_DC_BLOCK_GAIN_SATURATE_DEFINES_SVH

`ifndef SYNTHESIS

`define ADCDC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("adcdc assertion failed");

`define ADCDC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("adcdc assertion failed");

`else

`define ADCDC_ASSERT(lbl, clk, rst, prop)

`define ADCDC_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ===== rtl/core/adcdc_pkg.sv =====
// Shared types and constants for the DC blocking filter with gain and saturation.
// No dependencies; imported by every module of the block.
`default_nettype none

package adcdc_pkg;

  localparam int SAMPLE_BITS_DEF = 12;
  localparam int FRAC_BITS       = 16;
  localparam int DIV_BITS        = 16;
  localparam int GAIN_BITS       = 8;
  localparam int PCM_BITS        = 16;
  localparam int PCM_MAX         = 32767;
  localparam int PCM_MIN         = -32768;

  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [CFG_IDX_BITS-1:0] CFG_DC_DIVISOR = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PCM_GAIN   = 2'd1;

  localparam logic [DIV_BITS-1:0]  DIVISOR_RESET = 16'd64;
  localparam logic [GAIN_BITS-1:0] GAIN_RESET    = 8'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_UPDATE,
    ST_TRUNC,
    ST_SCALE,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic update;
    logic trunc;
    logic scale;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/adcdc_cfg.sv =====
// Configuration register file: DC follow divisor and output gain.
// Depends on adcdc_pkg for widths, register indexes and reset values.
`default_nettype none

module adcdc_cfg (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [adcdc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [adcdc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  output logic [adcdc_pkg::DIV_BITS-1:0]        dc_divisor,
  output logic [adcdc_pkg::GAIN_BITS-1:0]       pcm_gain
);
  import adcdc_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dc_divisor <= DIVISOR_RESET;
      pcm_gain   <= GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DC_DIVISOR: dc_divisor <= cfg_data[DIV_BITS-1:0];
        CFG_PCM_GAIN:   pcm_gain   <= cfg_data[GAIN_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/adcdc_dp.sv =====
// Datapath: DC estimate, restoring divider, truncation, gain multiply and
// saturating output register. Depends on adcdc_pkg and the assertion header.
`default_nettype none

`include "adc_dc_block_gain_saturate_defines.svh"

module adcdc_dp #(
  parameter int SAMPLE_BITS = adcdc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  adcdc_pkg::dp_cmd_t                   cmd,
  output adcdc_pkg::dp_status_t                status,
  input  logic [SAMPLE_BITS-1:0]               raw_sample,
  input  logic                                 restart,
  input  logic [adcdc_pkg::DIV_BITS-1:0]       dc_divisor,
  input  logic [adcdc_pkg::GAIN_BITS-1:0]      pcm_gain,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [adcdc_pkg::PCM_BITS-1:0] pcm_out,
  output logic                                 clipped
);
  import adcdc_pkg::*;

  localparam int QW   = SAMPLE_BITS + FRAC_BITS;
  localparam int CNTW = $clog2(QW);
  localparam int IW   = SAMPLE_BITS + 1;
  localparam int PW   = IW + GAIN_BITS + 1;

  localparam logic [QW-1:0]          MAX_EST  = {{SAMPLE_BITS{1'b1}}, {FRAC_BITS{1'b0}}};
  localparam logic [CNTW-1:0]        CNT_LAST = CNTW'(QW - 1);
  localparam logic signed [PW-1:0]   SAT_HI   = PW'(PCM_MAX);
  localparam logic signed [PW-1:0]   SAT_LO   = PW'(PCM_MIN);
  localparam logic [PCM_BITS-1:0]    PCM_HI   = PCM_BITS'(PCM_MAX);
  localparam logic [PCM_BITS-1:0]    PCM_LO   = PCM_BITS'(PCM_MIN);

  logic [QW-1:0]          est;
  logic                   dc_valid;
  logic [QW-1:0]          raw_q;
  logic                   neg;
  logic [QW-1:0]          quo;
  logic [DIV_BITS-1:0]    rem;
  logic [DIV_BITS-1:0]    dv;
  logic [CNTW-1:0]        cnt;
  logic signed [IW-1:0]   pint;
  logic signed [PW-1:0]   prod;

  logic [QW-1:0]          raw_q16;
  logic                   seed;
  logic [QW-1:0]          est_eff;
  logic [QW:0]            diff;
  logic [QW:0]            diff_neg;
  logic [QW-1:0]          diff_mag;
  logic [DIV_BITS:0]      rem_sh;
  logic [DIV_BITS:0]      rem_sub;
  logic                   fits;
  logic [QW:0]            q_ext;
  logic [QW:0]            q_s;
  logic [QW:0]            est_sum;
  logic [QW:0]            d2;
  logic                   round_up;
  logic signed [IW-1:0]   pint_next;
  logic signed [PW-1:0]   prod_next;
  logic [PCM_BITS-1:0]    pcm_next;
  logic                   clip_next;
  logic                   out_load;

  always_comb begin
    raw_q16  = {raw_sample, {FRAC_BITS{1'b0}}};
    seed     = restart | ~dc_valid;
    est_eff  = seed ? raw_q16 : est;
    diff     = {1'b0, raw_q16} - {1'b0, est_eff};
    diff_neg = -diff;
    diff_mag = diff[QW] ? diff_neg[QW-1:0] : diff[QW-1:0];

    rem_sh   = {rem, quo[QW-1]};
    rem_sub  = rem_sh - {1'b0, dv};
    fits     = (rem_sh >= {1'b0, dv});

    q_ext    = {1'b0, quo};
    q_s      = neg ? -q_ext : q_ext;
    est_sum  = {1'b0, est} + q_s;

    // The integer part is truncated toward zero, so a negative value with a
    // nonzero fraction rounds up from the arithmetic shift.
    d2        = {1'b0, raw_q} - {1'b0, est};
    round_up  = d2[QW] & (|d2[FRAC_BITS-1:0]);
    pint_next = $signed(d2[QW:FRAC_BITS]) + $signed({{(IW-1){1'b0}}, round_up});

    prod_next = pint * $signed({1'b0, pcm_gain});

    if (prod > SAT_HI) begin
      pcm_next  = PCM_HI;
      clip_next = 1'b1;
    end else if (prod < SAT_LO) begin
      pcm_next  = PCM_LO;
      clip_next = 1'b1;
    end else begin
      pcm_next  = prod[PCM_BITS-1:0];
      clip_next = 1'b0;
    end
  end

  assign status.div_done = (cnt == '0);
  assign status.out_free = ~out_valid | ~out_stall;
  assign out_load        = cmd.emit & status.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      est      <= '0;
      dc_valid <= 1'b0;
    end else if (cmd.load) begin
      est      <= est_eff;
      dc_valid <= 1'b1;
    end else if (cmd.update) begin
      est      <= est_sum[QW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      raw_q <= raw_q16;
      neg   <= diff[QW];
      quo   <= diff_mag;
      rem   <= '0;
      dv    <= (dc_divisor == '0) ? DIV_BITS'(1) : dc_divisor;
      cnt   <= CNT_LAST;
    end else if (cmd.div_step) begin
      quo <= {quo[QW-2:0], fits};
      rem <= fits ? rem_sub[DIV_BITS-1:0] : rem_sh[DIV_BITS-1:0];
      cnt <= cnt - CNTW'(1);
    end
    if (cmd.trunc) begin
      pint <= pint_next;
    end
    if (cmd.scale) begin
      prod <= prod_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      pcm_out <= pcm_next;
      clipped <= clip_next;
    end
  end

  `ADCDC_ASSERT(a_est_in_range, clk, rst, dc_valid |-> (est <= MAX_EST))
  `ADCDC_ASSERT(a_emit_sets_valid, clk, rst, out_load |=> out_valid)
  `ADCDC_ASSERT(a_clip_at_limit, clk, rst,
    (out_valid && clipped) |-> (pcm_out == PCM_HI || pcm_out == PCM_LO))

endmodule

`default_nettype wire

// ===== rtl/core/adcdc_ctrl.sv =====
// Controller state machine sequencing load, divide, update, truncate, scale and emit.
// Depends on adcdc_pkg for the state, command and status types.
`default_nettype none

`include "adc_dc_block_gain_saturate_defines.svh"

module adcdc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  output adcdc_pkg::dp_cmd_t    cmd,
  input  adcdc_pkg::dp_status_t status
);
  import adcdc_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_DIVIDE;
      ST_DIVIDE: if (status.div_done) state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_TRUNC;
      ST_TRUNC:  state_next = ST_SCALE;
      ST_SCALE:  state_next = ST_EMIT;
      ST_EMIT:   if (status.out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_DIVIDE: cmd.div_step = 1'b1;
      ST_UPDATE: cmd.update   = 1'b1;
      ST_TRUNC:  cmd.trunc    = 1'b1;
      ST_SCALE:  cmd.scale    = 1'b1;
      ST_EMIT:   cmd.emit     = status.out_free;
      default: begin
      end
    endcase
  end

  `ADCDC_ASSERT(a_load_starts_divide, clk, rst, cmd.load |=> (state == ST_DIVIDE))
  `ADCDC_ASSERT(a_emit_holds, clk, rst,
    (state == ST_EMIT && !status.out_free) |=> (state == ST_EMIT))
  `ADCDC_ASSERT_ALWAYS(a_one_command, clk,
    $onehot0({cmd.load, cmd.div_step, cmd.update, cmd.trunc, cmd.scale, cmd.emit}))

endmodule

`default_nettype wire

// ===== rtl/core/adc_dc_block_gain_saturate.sv =====
// DC blocking leaky integrator with gain and saturation, one sample word at a time.
// A new sample is accepted only in the idle state, after the previous word has been
// emitted; the one-bit-per-cycle restoring divider runs SAMPLE_BITS + 16 steps and the
// output handshake can hold the sequencer in its emit state.
// Synchronous reset clears the DC estimate and its seeded flag, the sequencer and
// the output valid, and loads divisor 64 and gain 1.
`default_nettype none

module adc_dc_block_gain_saturate #(
  parameter int SAMPLE_BITS = adcdc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [SAMPLE_BITS-1:0]                raw_sample,
  input  logic                                  restart,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [adcdc_pkg::PCM_BITS-1:0] pcm_out,
  output logic                                  clipped,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [adcdc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [adcdc_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import adcdc_pkg::*;

  logic [DIV_BITS-1:0]  dc_divisor;
  logic [GAIN_BITS-1:0] pcm_gain;
  dp_cmd_t              cmd;
  dp_status_t           status;

  adcdc_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .dc_divisor (dc_divisor),
    .pcm_gain   (pcm_gain)
  );

  adcdc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .status   (status)
  );

  adcdc_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .raw_sample (raw_sample),
    .restart    (restart),
    .dc_divisor (dc_divisor),
    .pcm_gain   (pcm_gain),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pcm_out    (pcm_out),
    .clipped    (clipped)
  );

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for adc_dc_block_gain_saturate: it predicts each output word
// from a local model of the DC tracker, gain and clamp, and compares it field by field.
// Depends on adcdc_pkg and the adc_dc_block_gain_saturate RTL.
`default_nettype none

module tb;
  import adcdc_pkg::*;

  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_3 = 2'd3;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_WORDS = 65;

  typedef struct {
    logic signed [PCM_BITS-1:0] pcm;
    logic                       clip;
  } pcm_word_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic [SAMPLE_BITS_DEF-1:0]       raw_sample = '0;
  logic                             restart = 1'b0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic signed [PCM_BITS-1:0]       pcm_out;
  logic                             clipped;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [CFG_IDX_BITS-1:0]          cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]         cfg_data = '0;

  logic [DIV_BITS-1:0]  model_divisor;
  logic [GAIN_BITS-1:0] model_gain;
  longint               model_dc_q16;
  bit                   model_seeded;

  pcm_word_t pending_words[$];
  int        mismatch_cnt = 0;
  int        burst_left = 0;
  int        stall_seg_left = 0;
  int        stall_mode = 0;

  adc_dc_block_gain_saturate i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .raw_sample (raw_sample),
    .restart    (restart),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pcm_out    (pcm_out),
    .clipped    (clipped),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic pcm_word_t filter_sample(input logic [SAMPLE_BITS_DEF-1:0] s,
                                              input logic reseed);
    longint    s_q16;
    longint    follow_div;
    longint    pcm;
    pcm_word_t w;
    s_q16 = longint'(s) << FRAC_BITS;
    follow_div = (model_divisor == '0) ? 64'sd1 : longint'(model_divisor);
    if (reseed || !model_seeded) begin
      model_dc_q16 = s_q16;
      model_seeded = 1'b1;
    end
    model_dc_q16 = model_dc_q16 + (s_q16 - model_dc_q16) / follow_div;
    pcm = ((s_q16 - model_dc_q16) / 65536) * longint'(model_gain);
    w.clip = 1'b0;
    if (pcm > PCM_MAX) begin
      pcm = PCM_MAX;
      w.clip = 1'b1;
    end
    if (pcm < PCM_MIN) begin
      pcm = PCM_MIN;
      w.clip = 1'b1;
    end
    w.pcm = pcm[PCM_BITS-1:0];
    return w;
  endfunction

  // Output words are checked in order against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        $error("unexpected output word: pcm_out %0d clipped %0b", pcm_out, clipped);
        mismatch_cnt++;
      end else begin
        if (pcm_out !== pending_words[0].pcm) begin
          $error("pcm_out expected %0d, got %0d", pending_words[0].pcm, pcm_out);
          mismatch_cnt++;
        end
        if (clipped !== pending_words[0].clip) begin
          $error("clipped expected %0b, got %0b", pending_words[0].clip, clipped);
          mismatch_cnt++;
        end
        void'(pending_words.pop_front());
      end
    end
  end

  // The receiver alternates between free-running, random and long-stall stretches.
  always @(posedge clk) begin
    if (stall_seg_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_seg_left <= $urandom_range(20, 200);
    end else begin
      stall_seg_left <= stall_seg_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= 1'($urandom_range(0, 1));
      default: out_stall <= (stall_seg_left % 16) < 11;
    endcase
  end

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_DC_DIVISOR: model_divisor = data;
      CFG_PCM_GAIN:   model_gain = data[GAIN_BITS-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_sample(input logic [SAMPLE_BITS_DEF-1:0] s, input logic reseed);
    in_valid <= 1'b1;
    raw_sample <= s;
    restart <= reseed;
    do @(posedge clk); while (in_stall);
    pending_words.push_back(filter_sample(s, reseed));
  endtask

  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 45);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_paced(input logic [SAMPLE_BITS_DEF-1:0] s, input logic reseed);
    send_sample(s, reseed);
    pace_sender();
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic test_seed_and_defaults();
    send_paced(12'h000, 1'b0);
    send_paced(12'hFFF, 1'b0);
    send_paced(12'h000, 1'b0);
    send_paced(12'hFFF, 1'b1);
    send_paced(12'h800, 1'b0);
    send_paced(12'h000, 1'b1);
  endtask

  task automatic test_register_extremes();
    wait_idle();
    // A zero divisor behaves as one, so the estimate lands on every sample.
    write_reg(CFG_DC_DIVISOR, 16'd0);
    write_reg(CFG_PCM_GAIN, 16'd255);
    send_paced(12'd100, 1'b1);
    send_paced(12'hFFF, 1'b0);
    send_paced(12'h000, 1'b0);
    send_paced(12'hFFF, 1'b0);
    wait_idle();
    write_reg(CFG_DC_DIVISOR, 16'hFFFF);
    send_paced(12'h000, 1'b1);
    send_paced(12'hFFF, 1'b0);
    send_paced(12'hFFF, 1'b1);
    send_paced(12'h000, 1'b0);
    wait_idle();
    // Upper data bits must not reach the gain register.
    write_reg(CFG_PCM_GAIN, 16'hFF00);
    send_paced(12'h000, 1'b1);
    send_paced(12'hFFF, 1'b0);
    wait_idle();
    write_reg(CFG_SPARE_2, 16'($urandom));
    write_reg(CFG_SPARE_3, 16'($urandom));
    write_reg(CFG_DC_DIVISOR, 16'd1);
    write_reg(CFG_PCM_GAIN, 16'd1);
    send_paced(12'd1000, 1'b0);
    send_paced(12'd3000, 1'b0);
    wait_idle();
    write_reg(CFG_DC_DIVISOR, 16'd2);
    write_reg(CFG_PCM_GAIN, 16'd8);
    send_paced(12'h000, 1'b1);
    send_paced(12'hFFF, 1'b0);
    send_paced(12'hFFF, 1'b0);
  endtask

  task automatic test_random_streams();
    logic [DIV_BITS-1:0]        div;
    logic [GAIN_BITS-1:0]       gain;
    logic [SAMPLE_BITS_DEF-1:0] level;
    logic [SAMPLE_BITS_DEF-1:0] s;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_idle();
      case ($urandom_range(0, 5))
        0: div = '0;
        1: div = 16'd1;
        2: div = 16'hFFFF;
        3: div = 16'($urandom_range(2, 16));
        default: div = 16'($urandom);
      endcase
      case ($urandom_range(0, 4))
        0: gain = '0;
        1: gain = 8'd1;
        2: gain = 8'hFF;
        default: gain = 8'($urandom);
      endcase
      if ($urandom_range(0, 3) == 0) begin
        write_reg(2'($urandom_range(CFG_SPARE_2, CFG_SPARE_3)), 16'($urandom));
      end
      write_reg(CFG_DC_DIVISOR, div);
      write_reg(CFG_PCM_GAIN, {8'($urandom), gain});
      level = 12'($urandom);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        case ($urandom_range(0, 3))
          0: s = 12'($urandom);
          1: s = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
          default: s = level ^ 12'($urandom_range(0, 63));
        endcase
        if ($urandom_range(0, 29) == 0) begin
          level = 12'($urandom);
        end
        send_paced(s, $urandom_range(0, 19) == 0);
      end
    end
  endtask

  initial begin
    model_divisor = DIVISOR_RESET;
    model_gain = GAIN_RESET;
    model_dc_q16 = 0;
    model_seeded = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_seed_and_defaults();
    test_register_extremes();
    test_random_streams();
    wait_idle();
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire
